// File: hdl/sequencing_read_stats_histogram_defines.svh
// Assertion macros shared by the histogram block
`ifndef SEQUENCING_READ_STATS_HISTOGRAM_DEFINES_SVH
`define SEQUENCING_READ_STATS_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SRSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define SRSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/srsh_pkg.sv
package srsh_pkg;

  localparam logic [2:0] SEL_QUAL  = 3'd0;
  localparam logic [2:0] SEL_BASE  = 3'd1;
  localparam logic [2:0] SEL_GC    = 3'd2;
  localparam logic [2:0] SEL_MEANQ = 3'd3;
  localparam logic [2:0] SEL_LEN   = 3'd4;

  localparam logic [2:0] NUC_C = 3'd1;
  localparam logic [2:0] NUC_G = 3'd2;
  localparam logic [2:0] NUC_N = 3'd4;
  localparam int NUC_CODES = 5;

  localparam int SAT9     = 511;
  localparam int MEAN_MAX = 255;

  typedef struct packed {
    logic       mode;
    logic [2:0] nucleotide;
    logic [7:0] quality;
    logic       last_base;
    logic [2:0] table_select;
    logic [7:0] position_index;
    logic [8:0] bin_index;
  } in_word_t;

  typedef struct packed {
    logic        read_done;
    logic [8:0]  read_length;
    logic [8:0]  gc_count;
    logic [7:0]  mean_quality;
    logic        overflow_flag;
    logic [31:0] count_value;
  } out_word_t;

  typedef enum logic [1:0] {
    K_PUSH,
    K_READ,
    K_ZERO
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] nuc;
    logic [7:0] qbin;
    logic [7:0] qual;
    logic       last;
    logic [2:0] sel;
    logic [7:0] pos;
    logic [8:0] bin;
  } cmd_t;

endpackage

// File: hdl/sequencing_read_stats_histogram.sv
// Channel | Handshake               | Word
// in      | in_valid / in_ready     | in_data  (srsh_pkg::in_word_t)
// out     | out_valid / out_ready   | out_data (srsh_pkg::out_word_t)
//
// A base does one read and one write-back of the two per-position RAMs (none past MAX_READ_LEN).
// A read-out passes through a registered RAM read, then the result register.
// Read end adds a bit-serial divide for the mean, then one read-modify-write
// of the three per-read histograms.
// After reset a clearing pass zeroes all RAMs; in_ready stays low meanwhile.
// A two-word queue decouples intake from execution; the back end stalls while a result waits.
module sequencing_read_stats_histogram #(
  parameter int MAX_READ_LEN = 256,
  parameter int QUALITY_BINS = 256,
  parameter int COUNTER_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srsh_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srsh_pkg::out_word_t out_data
);
  import srsh_pkg::*;

  logic clearing;
  logic q_valid, q_pop;
  cmd_t q_head;

  srsh_front #(
    .MAX_READ_LEN(MAX_READ_LEN),
    .QUALITY_BINS(QUALITY_BINS)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .clearing, .q_valid, .q_head, .q_pop
  );

  srsh_back #(
    .MAX_READ_LEN(MAX_READ_LEN),
    .QUALITY_BINS(QUALITY_BINS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_back (
    .clk, .rst_n, .clearing, .q_valid, .q_head, .q_pop,
    .out_valid, .out_ready, .out_data
  );

endmodule

// File: hdl/srsh_ram.sv
module srsh_ram #(
  parameter int W  = 32,
  parameter int D  = 256,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/srsh_front.sv
module srsh_front #(
  parameter int MAX_READ_LEN = 256,
  parameter int QUALITY_BINS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srsh_pkg::in_word_t in_data,
  input  logic             clearing,
  output logic             q_valid,
  output srsh_pkg::cmd_t   q_head,
  input  logic             q_pop
);
  import srsh_pkg::*;
  `include "sequencing_read_stats_histogram_defines.svh"

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       in_range;
  logic       push;

  always_comb begin
    unique case (in_data.table_select)
      SEL_QUAL:  in_range = (in_data.position_index < MAX_READ_LEN) &&
                            (in_data.bin_index < QUALITY_BINS);
      SEL_BASE:  in_range = (in_data.position_index < MAX_READ_LEN) &&
                            (in_data.bin_index < NUC_CODES);
      SEL_GC:    in_range = (in_data.bin_index <= MAX_READ_LEN);
      SEL_MEANQ: in_range = (in_data.bin_index < QUALITY_BINS);
      SEL_LEN:   in_range = (in_data.bin_index <= MAX_READ_LEN);
      default:   in_range = 1'b0;
    endcase
    cmd.kind = in_data.mode ? (in_range ? K_READ : K_ZERO) : K_PUSH;
    cmd.nuc  = (in_data.nucleotide > NUC_N) ? NUC_N : in_data.nucleotide;
    cmd.qbin = (in_data.quality >= QUALITY_BINS) ? 8'(QUALITY_BINS - 1) : in_data.quality;
    cmd.qual = in_data.quality;
    cmd.last = in_data.last_base;
    cmd.sel  = in_data.table_select;
    cmd.pos  = in_data.position_index;
    cmd.bin  = in_data.bin_index;
  end

  assign in_ready = (cnt_r != 2'd2) && !clearing;
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  `SRSH_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= 2'd2, "queue count out of range")
  `SRSH_ASSERT_NOW(a_pop_nonempty, q_pop, cnt_r != 2'd0, "pop from empty queue")
  `SRSH_ASSERT_NOW(a_stall_full, !in_ready && !clearing, cnt_r == 2'd2, "stall without full queue")

endmodule

// File: hdl/srsh_back.sv
module srsh_back #(
  parameter int MAX_READ_LEN = 256,
  parameter int QUALITY_BINS = 256,
  parameter int COUNTER_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  output logic               clearing,
  input  logic               q_valid,
  input  srsh_pkg::cmd_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output srsh_pkg::out_word_t out_data
);
  import srsh_pkg::*;
  `include "sequencing_read_stats_histogram_defines.svh"

  localparam int CB    = COUNTER_BITS;
  localparam int PA_W  = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
  localparam int QB_W  = $clog2(QUALITY_BINS);
  localparam int POS_W = $clog2(MAX_READ_LEN + 1);
  localparam int QA_W  = PA_W + QB_W;
  localparam int BA_W  = PA_W + 3;
  localparam int QD    = (2 ** PA_W) << QB_W;
  localparam int BD    = (2 ** PA_W) << 3;
  localparam int HD    = MAX_READ_LEN + 1;
  localparam int SUM_W = $clog2(MAX_READ_LEN * 255 + 1);
  localparam int NW    = SUM_W + 2;
  localparam int DW    = POS_W + 2;
  localparam int DC_W  = $clog2(NW + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PWR, S_RDAT, S_DSET, S_DIV, S_ERD, S_EWR
  } state_t;

  state_t          state_r;
  logic [QA_W-1:0] clr_r;
  cmd_t            cmd_r;
  logic [POS_W-1:0] pos_r, gc_r;
  logic [SUM_W-1:0] sum_r;
  logic            ovf_r;
  logic [NW-1:0]   num_r;
  logic [DW-1:0]   rem_r, den_r;
  logic [DC_W-1:0] dcnt_r;
  logic [7:0]      mean_r;
  logic            out_valid_r;
  out_word_t       out_r;

  logic            q_we, b_we, g_we, m_we, l_we;
  logic [QA_W-1:0] q_wa, q_ra;
  logic [BA_W-1:0] b_wa, b_ra;
  logic [POS_W-1:0] g_wa, g_ra, l_wa, l_ra;
  logic [QB_W-1:0] m_wa, m_ra, mbin;
  logic [CB-1:0]   q_wd, b_wd, g_wd, m_wd, l_wd;
  logic [CB-1:0]   q_rd, b_rd, g_rd, m_rd, l_rd;
  logic [CB-1:0]   rd_sel;
  logic            q_sat, b_sat, g_sat, m_sat, l_sat;
  logic [DW-1:0]   rem_sh;
  logic            drop;

  srsh_ram #(.W(CB), .D(QD)) u_qram (.clk, .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .raddr(q_ra), .rdata(q_rd));
  srsh_ram #(.W(CB), .D(BD)) u_bram (.clk, .we(b_we), .waddr(b_wa), .wdata(b_wd),
    .raddr(b_ra), .rdata(b_rd));
  srsh_ram #(.W(CB), .D(HD)) u_gram (.clk, .we(g_we), .waddr(g_wa), .wdata(g_wd),
    .raddr(g_ra), .rdata(g_rd));
  srsh_ram #(.W(CB), .D(QUALITY_BINS)) u_mram (.clk, .we(m_we), .waddr(m_wa), .wdata(m_wd),
    .raddr(m_ra), .rdata(m_rd));
  srsh_ram #(.W(CB), .D(HD)) u_lram (.clk, .we(l_we), .waddr(l_wa), .wdata(l_wd),
    .raddr(l_ra), .rdata(l_rd));

  assign clearing  = (state_r == S_CLEAR);
  assign q_pop     = (state_r == S_IDLE) && q_valid && !out_valid_r;
  assign drop      = (pos_r >= POS_W'(MAX_READ_LEN));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign mbin      = (mean_r >= QUALITY_BINS) ? QB_W'(QUALITY_BINS - 1) : mean_r[QB_W-1:0];
  assign rem_sh    = {rem_r[DW-2:0], num_r[NW-1]};

  assign q_sat = &q_rd;
  assign b_sat = &b_rd;
  assign g_sat = &g_rd;
  assign m_sat = &m_rd;
  assign l_sat = &l_rd;

  always_comb begin
    if (q_head.kind == K_PUSH) begin
      q_ra = {pos_r[PA_W-1:0], q_head.qbin[QB_W-1:0]};
      b_ra = {pos_r[PA_W-1:0], q_head.nuc};
    end else begin
      q_ra = {PA_W'(q_head.pos), q_head.bin[QB_W-1:0]};
      b_ra = {PA_W'(q_head.pos), q_head.bin[2:0]};
    end
    if (state_r == S_ERD) begin
      g_ra = gc_r;
      l_ra = pos_r;
      m_ra = mbin;
    end else begin
      g_ra = POS_W'(q_head.bin);
      l_ra = POS_W'(q_head.bin);
      m_ra = q_head.bin[QB_W-1:0];
    end
  end

  always_comb begin
    q_we = clearing;
    b_we = clearing;
    g_we = clearing;
    m_we = clearing;
    l_we = clearing;
    q_wa = clr_r;
    b_wa = clr_r[BA_W-1:0];
    g_wa = POS_W'(clr_r);
    l_wa = POS_W'(clr_r);
    m_wa = clr_r[QB_W-1:0];
    q_wd = '0;
    b_wd = '0;
    g_wd = '0;
    m_wd = '0;
    l_wd = '0;
    if (state_r == S_PWR) begin
      q_we = 1'b1;
      b_we = 1'b1;
      q_wa = {pos_r[PA_W-1:0], cmd_r.qbin[QB_W-1:0]};
      b_wa = {pos_r[PA_W-1:0], cmd_r.nuc};
      q_wd = q_sat ? q_rd : q_rd + CB'(1);
      b_wd = b_sat ? b_rd : b_rd + CB'(1);
    end
    if (state_r == S_EWR) begin
      g_we = 1'b1;
      m_we = 1'b1;
      l_we = 1'b1;
      g_wa = gc_r;
      l_wa = pos_r;
      m_wa = mbin;
      g_wd = g_sat ? g_rd : g_rd + CB'(1);
      m_wd = m_sat ? m_rd : m_rd + CB'(1);
      l_wd = l_sat ? l_rd : l_rd + CB'(1);
    end
  end

  always_comb begin
    unique case (cmd_r.sel)
      SEL_QUAL:  rd_sel = q_rd;
      SEL_BASE:  rd_sel = b_rd;
      SEL_GC:    rd_sel = g_rd;
      SEL_MEANQ: rd_sel = m_rd;
      SEL_LEN:   rd_sel = l_rd;
      default:   rd_sel = '0;
    endcase
    if (cmd_r.kind != K_READ) rd_sel = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pos_r       <= '0;
      gc_r        <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + QA_W'(1);
          if (clr_r == QA_W'(QD - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            cmd_r <= q_head;
            if (q_head.kind != K_PUSH) begin
              state_r <= S_RDAT;
            end else if (!drop) begin
              state_r <= S_PWR;
            end else begin
              ovf_r <= 1'b1;
              if (q_head.last) state_r <= S_DSET;
            end
          end
        end
        S_PWR: begin
          if (q_sat || b_sat) ovf_r <= 1'b1;
          pos_r <= pos_r + POS_W'(1);
          if (cmd_r.nuc == NUC_C || cmd_r.nuc == NUC_G) gc_r <= gc_r + POS_W'(1);
          sum_r <= sum_r + SUM_W'(cmd_r.qual);
          state_r <= cmd_r.last ? S_DSET : S_IDLE;
        end
        S_RDAT: begin
          out_valid_r         <= 1'b1;
          out_r.read_done     <= 1'b0;
          out_r.read_length   <= '0;
          out_r.gc_count      <= '0;
          out_r.mean_quality  <= '0;
          out_r.overflow_flag <= 1'b0;
          out_r.count_value   <= (CB > 32 && |(rd_sel >> 32)) ? 32'hFFFF_FFFF : 32'(rd_sel);
          state_r             <= S_IDLE;
        end
        S_DSET: begin
          num_r   <= {sum_r, 1'b0} + NW'(pos_r);
          den_r   <= DW'({pos_r, 1'b0});
          rem_r   <= '0;
          dcnt_r  <= DC_W'(NW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= den_r) begin
            rem_r <= rem_sh - den_r;
            num_r <= {num_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            num_r <= {num_r[NW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - DC_W'(1);
          if (dcnt_r == DC_W'(1)) state_r <= S_ERD;
        end
        S_ERD: begin
          state_r <= S_EWR;
        end
        S_EWR: begin
          out_valid_r         <= 1'b1;
          out_r.read_done     <= 1'b1;
          out_r.read_length   <= (pos_r > SAT9) ? 9'(SAT9) : 9'(pos_r);
          out_r.gc_count      <= (gc_r > SAT9) ? 9'(SAT9) : 9'(gc_r);
          out_r.mean_quality  <= mean_r;
          out_r.overflow_flag <= ovf_r || g_sat || m_sat || l_sat;
          out_r.count_value   <= '0;
          pos_r   <= '0;
          gc_r    <= '0;
          sum_r   <= '0;
          ovf_r   <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV && dcnt_r == DC_W'(1)) begin
      mean_r <= ({num_r[NW-2:0], rem_sh >= den_r} > MEAN_MAX) ? 8'(MEAN_MAX) :
                8'({num_r[NW-2:0], rem_sh >= den_r});
    end
  end

  `SRSH_ASSERT_NOW(a_clear_quiet, clearing, !out_valid_r, "result during clearing pass")
  `SRSH_ASSERT_NOW(a_div_len, state_r == S_DIV, den_r != '0, "divide by zero length")
  `SRSH_ASSERT_NOW(a_gc_le_len, 1'b1, gc_r <= pos_r, "gc count above read length")
  `SRSH_ASSERT_NOW(a_done_zero, out_valid_r && out_r.read_done, out_r.count_value == '0,
    "read-end result carries a count")

endmodule
